>>> hdl/assert_macros.svh
// Assertion helpers. Both expect clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// ante |-> cons, checked at every rising edge out of reset
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante |=> cons, cons checked in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/lsps_pkg.sv
package lsps_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int N_SENS          = 8;
    localparam int MODE_W          = 3;
    localparam int ERR_W           = 14;
    localparam int GAIN_W          = 10;
    localparam int SPEED_W         = 8;
    localparam int DUTY_W          = 8;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = GAIN_W;
    localparam int CNT_W           = $clog2(N_SENS + 1);
    localparam int DIVIDEND_W      = ERR_W;
    localparam int WSUM_W          = ERR_W + 1;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FINISH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FOLLOW = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_SPEED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SPEED    = 8'd3;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = 10'd50;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST     = 10'd300;
    localparam logic [SPEED_W-1:0] STRAIGHT_SPEED_RST = 8'd200;
    localparam logic [SPEED_W-1:0] CURVE_SPEED_RST    = 8'd130;

    localparam logic signed [ERR_W-1:0] LOST_POS = 14'sd4500;
    localparam logic signed [ERR_W-1:0] LOST_NEG = -14'sd4500;

    localparam logic signed [WSUM_W-1:0] SENS_WEIGHT [N_SENS] = '{
        -15'sd4000, -15'sd3000, -15'sd2000, -15'sd1000,
        15'sd1000, 15'sd2000, 15'sd3000, 15'sd4000
    };

    localparam int  GAIN_SCALE   = 1000;
    localparam int  EFFORT_CAP   = 100;
    localparam int  DUTY_MAX     = 255;
    localparam int  RECIP_G_SH   = 34;
    localparam int  RECIP_E_SH   = 22;
    localparam longint RECIP_GAIN   = (64'sd1 <<< RECIP_G_SH) / GAIN_SCALE;
    localparam longint RECIP_EFFORT = (64'sd1 <<< RECIP_E_SH) / EFFORT_CAP;

    typedef struct packed {
        logic clear;
        logic track;
        logic finish;
    } lane_op_t;

    typedef struct packed {
        logic                  valid;
        logic                  lost;
        logic                  neg;
        logic [DIVIDEND_W-1:0] dividend;
        logic [CNT_W-1:0]      count;
    } merge_t;

    typedef struct packed {
        logic              right_reverse;
        logic [DUTY_W-1:0] right_duty;
        logic              left_reverse;
        logic [DUTY_W-1:0] left_duty;
    } pd_result_t;

    // first field in the high bits
    typedef struct packed {
        logic                    line_lost;
        logic signed [ERR_W-1:0] line_error;
        logic                    right_reverse;
        logic [DUTY_W-1:0]       right_duty;
        logic                    left_reverse;
        logic [DUTY_W-1:0]       left_duty;
    } out_item_t;

    localparam int OUT_W    = $bits(out_item_t);
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

endpackage

>>> hdl/lsps_lane.sv
`include "assert_macros.svh"

module lsps_lane #(
    parameter int SAMPLE_BITS = lsps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsps_pkg::lane_op_t     op,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   hit
);
    import lsps_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] FULL = '1;
    localparam logic [SAMPLE_BITS-1:0] HALF = FULL >> 1;

    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] thr_reg, thr_next;
    logic [SAMPLE_BITS:0]   mid_sum;

    assign mid_sum = {1'b0, min_reg} + {1'b0, max_reg};

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        thr_next = thr_reg;
        if (op.clear)
        begin
            min_next = FULL;
            max_next = '0;
        end
        if (op.track)
        begin
            if (sample < min_reg)
            begin
                min_next = sample;
            end
            if (sample > max_reg)
            begin
                max_next = sample;
            end
        end
        if (op.finish)
        begin
            thr_next = mid_sum[SAMPLE_BITS:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= FULL;
            max_reg <= '0;
            thr_reg <= HALF;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            thr_reg <= thr_next;
        end
    end

    assign hit = sample > thr_reg;

endmodule

>>> hdl/lsps_merge.sv
module lsps_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lsps_pkg::N_SENS-1:0]   hits,
    output lsps_pkg::merge_t              res
);
    import lsps_pkg::*;

    logic signed [WSUM_W-1:0] wsum;
    logic signed [WSUM_W-1:0] wabs;
    logic [CNT_W-1:0]         cnt;
    merge_t                   res_reg, res_next;

    // weights are spaced so that the sum stays within +/-10000
    always_comb
    begin
        wsum = '0;
        for (int i = 0; i < N_SENS; i++)
        begin
            if (hits[i])
            begin
                wsum = wsum + SENS_WEIGHT[i];
            end
        end
        cnt  = CNT_W'($countones(hits));
        wabs = wsum[WSUM_W-1] ? -wsum : wsum;
    end

    always_comb
    begin
        res_next       = res_reg;
        res_next.valid = start;
        if (start)
        begin
            res_next.lost     = (cnt == '0);
            res_next.neg      = wsum[WSUM_W-1];
            res_next.dividend = wabs[DIVIDEND_W-1:0];
            res_next.count    = cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> hdl/lsps_div.sv
`include "assert_macros.svh"

module lsps_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lsps_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [lsps_pkg::CNT_W-1:0]      divisor,
    output logic                            done,
    output logic [lsps_pkg::DIVIDEND_W-1:0] quotient
);
    import lsps_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        trial_sub;
    logic                  fits;

    // restoring division, one quotient bit per cycle, MSB first
    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `ASSERT_IMPLY(a_div_start_idle, start, !busy_reg)
    `ASSERT_IMPLY(a_div_nonzero, start, divisor != '0)

endmodule

>>> hdl/lsps_pd.sv
module lsps_pd (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [lsps_pkg::ERR_W-1:0]   error,
    input  logic signed [lsps_pkg::ERR_W-1:0]   prev_error,
    input  logic [lsps_pkg::GAIN_W-1:0]         prop_gain,
    input  logic [lsps_pkg::GAIN_W-1:0]         deriv_gain,
    input  logic [lsps_pkg::SPEED_W-1:0]        straight_speed,
    input  logic [lsps_pkg::SPEED_W-1:0]        curve_speed,
    output logic                                done,
    output lsps_pkg::pd_result_t                res
);
    import lsps_pkg::*;

    localparam int NSTG   = 8;
    localparam int NUM_W  = 26;
    localparam int MAG_W  = 24;
    localparam int RG_W   = 25;
    localparam int Q_W    = 14;
    localparam int U_W    = Q_W + 1;
    localparam int A_W    = 7;
    localparam int P_W    = 17;
    localparam int PM_W   = 15;
    localparam int RE_W   = 16;
    localparam int B_W    = 10;
    localparam int D_W    = 16;

    localparam logic [RG_W-1:0]  RG_K    = RG_W'(RECIP_GAIN);
    localparam logic [RE_W-1:0]  RE_K    = RE_W'(RECIP_EFFORT);
    localparam logic [MAG_W-1:0] SCALE_K = MAG_W'(GAIN_SCALE);
    localparam logic [PM_W-1:0]  CAP_K   = PM_W'(EFFORT_CAP);
    localparam logic [A_W-1:0]   CAP_A   = A_W'(EFFORT_CAP);

    logic [NSTG-1:0] vld_reg;

    logic signed [NUM_W-1:0]   pp_reg, dd_reg;
    logic                      neg_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [Q_W-1:0]            q0_reg;
    logic signed [U_W-1:0]     u_reg;
    logic                      pneg_reg;
    logic [PM_W-1:0]           pmag_reg;
    logic [DUTY_W-1:0]         qb0_reg;
    logic signed [B_W-1:0]     base_reg;
    pd_result_t                res_reg;

    // stage 1: gains times error and error change
    logic signed [U_W-1:0]   e_ext, de;
    logic signed [NUM_W-1:0] kp_x, kd_x, e_x, de_x;
    assign e_ext = {error[ERR_W-1], error};
    assign de    = e_ext - {prev_error[ERR_W-1], prev_error};
    assign kp_x  = {{(NUM_W-GAIN_W){1'b0}}, prop_gain};
    assign kd_x  = {{(NUM_W-GAIN_W){1'b0}}, deriv_gain};
    assign e_x   = {{(NUM_W-U_W){e_ext[U_W-1]}}, e_ext};
    assign de_x  = {{(NUM_W-U_W){de[U_W-1]}}, de};

    // stage 2: sum, sign and magnitude
    logic signed [NUM_W-1:0] num, num_abs;
    assign num     = pp_reg + dd_reg;
    assign num_abs = num[NUM_W-1] ? -num : num;

    // stage 3: /1000 by reciprocal, may come out one low
    logic [MAG_W+RG_W-1:0] mq;
    assign mq = {{RG_W{1'b0}}, mag_reg} * {{MAG_W{1'b0}}, RG_K};

    // stage 4: correction and sign
    logic [MAG_W-1:0] chk, rem;
    logic [Q_W-1:0]   q;
    logic [U_W-1:0]   q_ext;
    assign chk   = {{(MAG_W-Q_W){1'b0}}, q0_reg} * SCALE_K;
    assign rem   = mag_reg - chk;
    assign q     = (rem >= SCALE_K) ? q0_reg + 1'b1 : q0_reg;
    assign q_ext = {1'b0, q};

    // stage 5: effort times speed span
    logic [U_W-1:0]        u_abs;
    logic [A_W-1:0]        effort;
    logic signed [SPEED_W:0] span;
    logic signed [P_W-1:0] p, p_abs;
    assign u_abs  = u_reg[U_W-1] ? -u_reg : u_reg;
    assign effort = (u_abs > U_W'(EFFORT_CAP)) ? CAP_A : u_abs[A_W-1:0];
    assign span   = {1'b0, curve_speed} - {1'b0, straight_speed};
    assign p      = {{(P_W-A_W){1'b0}}, effort} * {{(P_W-SPEED_W-1){span[SPEED_W]}}, span};
    assign p_abs  = p[P_W-1] ? -p : p;

    // stage 6: /100 by reciprocal
    logic [PM_W+RE_W-1:0] mb;
    assign mb = {{RE_W{1'b0}}, pmag_reg} * {{PM_W{1'b0}}, RE_K};

    // stage 7: correction, base duty
    logic [PM_W-1:0]   chk2, rem2;
    logic [DUTY_W-1:0] qb;
    logic signed [B_W-1:0] qb_s;
    assign chk2 = {{(PM_W-DUTY_W){1'b0}}, qb0_reg} * CAP_K;
    assign rem2 = pmag_reg - chk2;
    assign qb   = (rem2 >= CAP_K) ? qb0_reg + 1'b1 : qb0_reg;
    assign qb_s = pneg_reg ? -{2'b00, qb} : {2'b00, qb};

    // stage 8: wheel drive
    logic signed [D_W-1:0] left_v, right_v;
    assign left_v  = {{(D_W-B_W){base_reg[B_W-1]}}, base_reg} - {u_reg[U_W-1], u_reg};
    assign right_v = {{(D_W-B_W){base_reg[B_W-1]}}, base_reg} + {u_reg[U_W-1], u_reg};

    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [D_W-1:0] v);
        logic [D_W-1:0] mag;
        mag = v[D_W-1] ? -v : v;
        return (mag > D_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : mag[DUTY_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pp_reg <= kp_x * e_x;
            dd_reg <= kd_x * de_x;
        end
        if (vld_reg[0])
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num_abs[MAG_W-1:0];
        end
        if (vld_reg[1])
        begin
            q0_reg <= mq[RECIP_G_SH +: Q_W];
        end
        if (vld_reg[2])
        begin
            u_reg <= neg_reg ? -q_ext : q_ext;
        end
        if (vld_reg[3])
        begin
            pneg_reg <= p[P_W-1];
            pmag_reg <= p_abs[PM_W-1:0];
        end
        if (vld_reg[4])
        begin
            qb0_reg <= mb[RECIP_E_SH +: DUTY_W];
        end
        if (vld_reg[5])
        begin
            base_reg <= {2'b00, straight_speed} + qb_s;
        end
        if (vld_reg[6])
        begin
            res_reg.left_duty     <= sat_duty(left_v);
            res_reg.left_reverse  <= left_v[D_W-1];
            res_reg.right_duty    <= sat_duty(right_v);
            res_reg.right_reverse <= right_v[D_W-1];
        end
    end

    assign done = vld_reg[NSTG-1];
    assign res  = res_reg;

endmodule

>>> hdl/line_sensor_pd_steering_top.sv
// Eight-sensor line follower with PD steering. One frame per item: mode on
// s_tuser, eight samples on s_tdata; one result item per frame. Modes 1-3 run
// sensor calibration (clear, track min/max, set thresholds at the midpoint)
// and return an all-zero result, as do idle and unused codes. Follow mode
// compares each sensor against its threshold in eight parallel lanes, merges
// the hits into a weighted position, divides by the hit count and runs the PD
// law and speed mapping. When the line is lost the serial position divider
// is skipped. One frame is processed at a time; the next is accepted once
// the current result sits in the output register. Gains and speeds are
// written through the cfg port; the user must do so only while no frame is
// in flight, as the block itself does not enforce this.
`include "assert_macros.svh"

module line_sensor_pd_steering_top #(
    parameter int SAMPLE_BITS = lsps_pkg::SAMPLE_BITS_DEF,
    localparam int S_DATA_W = ((lsps_pkg::N_SENS * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample_0 .. sample_7, SAMPLE_BITS each, sample_0 lowest
    input  logic [S_DATA_W-1:0]                 s_tdata,
    // mode
    input  logic [lsps_pkg::MODE_W-1:0]         s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_duty, left_reverse, right_duty, right_reverse, line_error,
    // line_lost, then zero fill
    output logic [lsps_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lsps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LANE,
        ST_CALC,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [GAIN_W-1:0]       kp_reg, kp_next;
    logic [GAIN_W-1:0]       kd_reg, kd_next;
    logic [SPEED_W-1:0]      straight_reg, straight_next;
    logic [SPEED_W-1:0]      curve_reg, curve_next;
    logic signed [ERR_W-1:0] e_reg, e_next;
    logic                    lost_reg, lost_next;
    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;
    logic signed [ERR_W-1:0] last_seen_reg, last_seen_next;
    logic                    pd_start_reg, pd_start_next;
    out_item_t               res_reg, res_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [SAMPLE_BITS-1:0]  sample_reg [N_SENS];
    logic [N_SENS-1:0]       hits;
    lane_op_t                lane_op;
    merge_t                  merge_res;
    logic                    div_done;
    logic [DIVIDEND_W-1:0]   div_q;
    logic signed [ERR_W-1:0] div_err;
    logic                    pd_done;
    pd_result_t              pd_res;
    logic                    accept;
    logic                    lost_done;
    logic                    lost_err_ok;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < N_SENS; i++)
            begin
                sample_reg[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    always_comb
    begin
        lane_op        = '0;
        lane_op.clear  = (state_reg == ST_LANE) && (mode_reg == MODE_CLEAR);
        lane_op.track  = (state_reg == ST_LANE) && (mode_reg == MODE_SAMPLE);
        lane_op.finish = (state_reg == ST_LANE) && (mode_reg == MODE_FINISH);
    end

    for (genvar g = 0; g < N_SENS; g++)
    begin : g_lane
        lsps_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .op     (lane_op),
            .sample (sample_reg[g]),
            .hit    (hits[g])
        );
    end

    lsps_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((state_reg == ST_LANE) && (mode_reg == MODE_FOLLOW)),
        .hits  (hits),
        .res   (merge_res)
    );

    lsps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (merge_res.valid && !merge_res.lost),
        .dividend (merge_res.dividend),
        .divisor  (merge_res.count),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_err = merge_res.neg ? -div_q : div_q;

    lsps_pd u_pd (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (pd_start_reg),
        .error          (e_reg),
        .prev_error     (prev_err_reg),
        .prop_gain      (kp_reg),
        .deriv_gain     (kd_reg),
        .straight_speed (straight_reg),
        .curve_speed    (curve_reg),
        .done           (pd_done),
        .res            (pd_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        kp_next        = kp_reg;
        kd_next        = kd_reg;
        straight_next  = straight_reg;
        curve_next     = curve_reg;
        e_next         = e_reg;
        lost_next      = lost_reg;
        prev_err_next  = prev_err_reg;
        last_seen_next = last_seen_reg;
        pd_start_next  = 1'b0;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROP_GAIN:      kp_next       = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:     kd_next       = cfg_data[GAIN_W-1:0];
                REG_STRAIGHT_SPEED: straight_next = cfg_data[SPEED_W-1:0];
                REG_CURVE_SPEED:    curve_next    = cfg_data[SPEED_W-1:0];
                default:            ;
            endcase
        end

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    state_next = ST_LANE;
                end
            end
            ST_LANE:
            begin
                if (mode_reg == MODE_FOLLOW)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_CALC:
            begin
                if (merge_res.valid && merge_res.lost)
                begin
                    e_next        = (last_seen_reg > 0) ? LOST_POS : LOST_NEG;
                    lost_next     = 1'b1;
                    pd_start_next = 1'b1;
                end
                if (div_done)
                begin
                    e_next         = div_err;
                    lost_next      = 1'b0;
                    last_seen_next = div_err;
                    pd_start_next  = 1'b1;
                end
                // pd has taken the old value on this edge
                if (pd_start_reg)
                begin
                    prev_err_next = e_reg;
                end
                if (pd_done)
                begin
                    res_next.left_duty     = pd_res.left_duty;
                    res_next.left_reverse  = pd_res.left_reverse;
                    res_next.right_duty    = pd_res.right_duty;
                    res_next.right_reverse = pd_res.right_reverse;
                    res_next.line_error    = e_reg;
                    res_next.line_lost     = lost_reg;
                    state_next             = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = M_DATA_W'(res_reg);
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDLE;
            kp_reg        <= PROP_GAIN_RST;
            kd_reg        <= DERIV_GAIN_RST;
            straight_reg  <= STRAIGHT_SPEED_RST;
            curve_reg     <= CURVE_SPEED_RST;
            e_reg         <= '0;
            lost_reg      <= 1'b0;
            prev_err_reg  <= '0;
            last_seen_reg <= '0;
            pd_start_reg  <= 1'b0;
            res_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            kp_reg        <= kp_next;
            kd_reg        <= kd_next;
            straight_reg  <= straight_next;
            curve_reg     <= curve_next;
            e_reg         <= e_next;
            lost_reg      <= lost_next;
            prev_err_reg  <= prev_err_next;
            last_seen_reg <= last_seen_next;
            pd_start_reg  <= pd_start_next;
            res_reg       <= res_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign lost_done   = (state_reg == ST_DONE) && res_reg.line_lost;
    assign lost_err_ok = (res_reg.line_error == LOST_POS) || (res_reg.line_error == LOST_NEG);

    `ASSERT_IMPLY(a_lost_err, lost_done, lost_err_ok)
    `ASSERT_IMPLY(a_pd_start_calc, pd_start_reg, state_reg == ST_CALC)
    `ASSERT_NEXT(a_div_then_pd, div_done, pd_start_reg)

endmodule

>>> bench/line_sensor_pd_steering_top_tb.sv
module line_sensor_pd_steering_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsps_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int S_W = ((N_SENS * SB + 7) / 8) * 8;
    localparam int S_TOP = (1 << SB) - 1;
    localparam int S_MID = S_TOP / 2;
    localparam int LOW_TOP = S_TOP * 3 / 10;
    localparam int HIGH_BOT = S_TOP * 7 / 10;
    localparam int N_PHASES = 6;
    localparam int PHASE_ITEMS = 105;
    localparam int HOLD_AT = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;

    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP = 8'hFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [S_W-1:0]    samples;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [S_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0] s_tuser = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_t pending[$];
    out_item_t expected_out[$];
    frame_t src_frame;
    int errors = 0;
    int idle_pct = 15;
    int src_gap = 0;
    int sink_gap = 0;
    int results_seen = 0;
    bit hold_done = 1'b0;
    int stall_cycles = 0;

    // steering model: gains, speeds and calibration state
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
    logic [SPEED_W-1:0] v_straight;
    logic [SPEED_W-1:0] v_curve;
    logic [SB-1:0] cal_lo [N_SENS];
    logic [SB-1:0] cal_hi [N_SENS];
    logic [SB-1:0] thresh [N_SENS];
    int prev_err;
    int seen_err;

    line_sensor_pd_steering_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int sensor_weight(input int i);
        return (i < N_SENS / 2) ? (i - N_SENS / 2) * 1000 : (i - N_SENS / 2 + 1) * 1000;
    endfunction

    function automatic void drive_wheel(input int v, output logic [DUTY_W-1:0] duty,
                                       output logic rev);
        int mag;
        mag = (v < 0) ? -v : v;
        rev = (v < 0);
        duty = (mag > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : DUTY_W'(mag);
    endfunction

    function automatic out_item_t steer_step(input frame_t f);
        out_item_t r;
        logic [SB-1:0] smp;
        int i;
        int lo_hi;
        int sum;
        int cnt;
        int e;
        int u;
        int effort;
        int base;
        r = '0;
        sum = 0;
        cnt = 0;
        case (f.mode)
            MODE_CLEAR:
                for (i = 0; i < N_SENS; i++)
                begin
                    cal_lo[i] = S_TOP;
                    cal_hi[i] = '0;
                end
            MODE_SAMPLE:
                for (i = 0; i < N_SENS; i++)
                begin
                    smp = f.samples[i*SB +: SB];
                    if (smp < cal_lo[i])
                        cal_lo[i] = smp;
                    if (smp > cal_hi[i])
                        cal_hi[i] = smp;
                end
            MODE_FINISH:
                for (i = 0; i < N_SENS; i++)
                begin
                    lo_hi = cal_lo[i] + cal_hi[i];
                    thresh[i] = SB'(lo_hi >> 1);
                end
            MODE_FOLLOW:
            begin
                for (i = 0; i < N_SENS; i++)
                begin
                    smp = f.samples[i*SB +: SB];
                    if (smp > thresh[i])
                    begin
                        sum += sensor_weight(i);
                        cnt++;
                    end
                end
                r.line_lost = (cnt == 0);
                if (cnt == 0)
                    e = (seen_err > 0) ? int'(LOST_POS) : int'(LOST_NEG);
                else
                begin
                    e = sum / cnt;
                    seen_err = e;
                end
                u = (int'(kp) * e + int'(kd) * (e - prev_err)) / GAIN_SCALE;
                prev_err = e;
                effort = (u < 0) ? -u : u;
                if (effort > EFFORT_CAP)
                    effort = EFFORT_CAP;
                base = int'(v_straight)
                     + (effort * (int'(v_curve) - int'(v_straight))) / EFFORT_CAP;
                drive_wheel(base - u, r.left_duty, r.left_reverse);
                drive_wheel(base + u, r.right_duty, r.right_reverse);
                r.line_error = ERR_W'(e);
            end
            default: ;  // idle and unused codes
        endcase
        return r;
    endfunction

    // sensors flagged in hot draw from the high range, the rest from the low range
    function automatic frame_t make_frame(input logic [MODE_W-1:0] m, input int lo_a,
                                          input int lo_b, input int hi_a, input int hi_b,
                                          input logic [N_SENS-1:0] hot);
        frame_t f;
        int i;
        f = '0;
        f.mode = m;
        for (i = 0; i < N_SENS; i++)
            f.samples[i*SB +: SB] = hot[i] ? SB'($urandom_range(hi_b, hi_a))
                                           : SB'($urandom_range(lo_b, lo_a));
        return f;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PROP_GAIN:      kp = val;
            REG_DERIV_GAIN:     kd = val;
            REG_STRAIGHT_SPEED: v_straight = val[SPEED_W-1:0];
            REG_CURVE_SPEED:    v_curve = val[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(posedge clk);
    endtask

    // mostly calibration runs and line-following bursts, some noise frames
    task automatic queue_random(input int n);
        int pick;
        int len;
        int c;
        logic [N_SENS-1:0] hot;
        while (pending.size() < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                pending.push_back(make_frame(MODE_CLEAR, 0, S_TOP, 0, 0, '0));
                pending.push_back(make_frame(MODE_SAMPLE, 0, LOW_TOP, 0, 0, '0));
                pending.push_back(make_frame(MODE_SAMPLE, 0, 0, HIGH_BOT, S_TOP, '1));
                len = $urandom_range(0, 4);
                repeat (len)
                    pending.push_back(make_frame(MODE_SAMPLE, 0, LOW_TOP, HIGH_BOT, S_TOP,
                                                 N_SENS'($urandom)));
                if ($urandom_range(0, 7) != 0)
                    pending.push_back(make_frame(MODE_FINISH, 0, S_TOP, 0, 0, '0));
            end
            else if (pick < 8)
            begin
                len = $urandom_range(3, 12);
                repeat (len)
                begin
                    c = $urandom_range(0, N_SENS - 1);
                    hot = N_SENS'(((1 << $urandom_range(1, 3)) - 1) << c);
                    if ($urandom_range(0, 9) == 0)
                        hot[$urandom_range(0, N_SENS - 1)] = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        hot = '0;
                    pending.push_back(make_frame(MODE_FOLLOW, 0, LOW_TOP, HIGH_BOT, S_TOP,
                                                 hot));
                end
            end
            else
                pending.push_back(make_frame(MODE_W'($urandom_range(0, 7)), 0, S_TOP, 0, 0,
                                             '0));
        end
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                expected_out.push_back(steer_step(frame_t'({s_tuser, s_tdata})));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    src_frame = pending.pop_front();
                    s_tuser <= src_frame.mode;
                    s_tdata <= src_frame.samples;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 99) < idle_pct)
                        src_gap = $urandom_range(1, 18);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result side; one long hold-off lets the source back up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                results_seen++;
            if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_done = 1'b1;
                sink_gap = HOLD_CYCLES;
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < idle_pct)
                    sink_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t got;
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = out_item_t'(m_tdata[OUT_W-1:0]);
            if (expected_out.size() == 0)
            begin
                $error("result item with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_out.pop_front();
                check_field("left_duty", want.left_duty, got.left_duty);
                check_field("left_reverse", want.left_reverse, got.left_reverse);
                check_field("right_duty", want.right_duty, got.right_duty);
                check_field("right_reverse", want.right_reverse, got.right_reverse);
                check_field("line_error", int'(want.line_error), int'(got.line_error));
                check_field("line_lost", want.line_lost, got.line_lost);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("line_sensor_pd_steering_top verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int i;
        int phase;
        kp = PROP_GAIN_RST;
        kd = DERIV_GAIN_RST;
        v_straight = STRAIGHT_SPEED_RST;
        v_curve = CURVE_SPEED_RST;
        for (i = 0; i < N_SENS; i++)
        begin
            cal_lo[i] = S_TOP;
            cal_hi[i] = '0;
            thresh[i] = S_MID;
        end
        prev_err = 0;
        seen_err = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds sit at mid scale; no line seen yet, so lost goes left
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, S_TOP, S_TOP, 8'hFF));
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, S_TOP, S_TOP, 8'h01));
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, S_TOP, S_TOP, 8'h80));
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, S_TOP, S_TOP, 8'h00));
        // one count above threshold vs. exactly at it; uneven averages truncate
        pending.push_back(make_frame(MODE_FOLLOW, S_MID, S_MID, S_MID + 1, S_MID + 1, 8'h0B));
        pending.push_back(make_frame(MODE_FOLLOW, S_MID, S_MID, S_MID + 1, S_MID + 1, 8'hD0));
        pending.push_back(make_frame(MODE_FOLLOW, S_MID, S_MID, S_MID + 1, S_MID + 1, 8'h07));
        pending.push_back(make_frame(MODE_FOLLOW, S_MID, S_MID, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_IDLE, 0, 0, S_TOP, S_TOP, 8'hFF));
        pending.push_back(make_frame(MODE_SPARE, 0, 0, S_TOP, S_TOP, 8'hFF));
        // finish straight out of reset keeps mid scale
        pending.push_back(make_frame(MODE_FINISH, 0, 0, S_TOP, S_TOP, 8'hFF));
        pending.push_back(make_frame(MODE_FOLLOW, S_MID, S_MID, S_MID + 1, S_MID + 1, 8'h3C));
        // only full-scale seen: threshold at the top, nothing can exceed it
        pending.push_back(make_frame(MODE_SAMPLE, 0, 0, S_TOP, S_TOP, 8'hFF));
        pending.push_back(make_frame(MODE_FINISH, 0, 0, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, S_TOP, S_TOP, 8'hFF));
        // clear ignores its own samples
        pending.push_back(make_frame(MODE_CLEAR, 0, 0, S_TOP, S_TOP, 8'hFF));
        pending.push_back(make_frame(MODE_SAMPLE, 0, 0, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_FINISH, 0, 0, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, 1, 1, 8'h01));
        pending.push_back(make_frame(MODE_CLEAR, 0, S_TOP, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_SAMPLE, 0, 0, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_SAMPLE, 0, 0, S_TOP, S_TOP, 8'hFF));
        pending.push_back(make_frame(MODE_FINISH, 0, 0, 0, 0, 8'h00));
        pending.push_back(make_frame(MODE_FOLLOW, 0, 0, S_TOP, S_TOP, 8'h18));
        wait_drained();

        for (phase = 0; phase < N_PHASES; phase++)
        begin
            // upper data bits on the speed writes must be dropped
            case (phase)
                0:
                begin
                    write_reg(REG_PROP_GAIN, 10'h3FF);
                    write_reg(REG_DERIV_GAIN, 10'h3FF);
                    write_reg(REG_STRAIGHT_SPEED, 10'h3FF);
                    write_reg(REG_CURVE_SPEED, 10'h300);
                end
                1:
                begin
                    write_reg(REG_PROP_GAIN, 10'h000);
                    write_reg(REG_DERIV_GAIN, 10'h000);
                    write_reg(REG_STRAIGHT_SPEED, 10'h100);
                    write_reg(REG_CURVE_SPEED, 10'h2FF);
                end
                2:
                begin
                    write_reg(REG_PROP_GAIN, 10'h000);
                    write_reg(REG_DERIV_GAIN, 10'h3FF);
                    write_reg(REG_STRAIGHT_SPEED, 10'h0FF);
                    write_reg(REG_CURVE_SPEED, 10'h0FF);
                end
                3:
                begin
                    write_reg(REG_PROP_GAIN, 10'h3FF);
                    write_reg(REG_DERIV_GAIN, 10'h000);
                    write_reg(REG_STRAIGHT_SPEED, 10'h000);
                    write_reg(REG_CURVE_SPEED, 10'h000);
                end
                default:
                begin
                    write_reg(REG_PROP_GAIN, CFG_DATA_W'($urandom));
                    write_reg(REG_DERIV_GAIN, CFG_DATA_W'($urandom));
                    write_reg(REG_STRAIGHT_SPEED, CFG_DATA_W'($urandom));
                    write_reg(REG_CURVE_SPEED, CFG_DATA_W'($urandom));
                end
            endcase
            write_reg((phase % 2 == 0) ? REG_NONE : REG_TOP, CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;

            if (phase == N_PHASES - 1)
                idle_pct = 0;
            else
                idle_pct = (phase % 2 == 0) ? 25 : 6;
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("line_sensor_pd_steering_top verification clean");
        else
            $display("line_sensor_pd_steering_top verification failed");
        $finish;
    end

endmodule
